// File: rtl/core/spol_pkg.sv
// shared types and constants for the stable priority-ordered list
// no dependencies; imported by the list module, its checker and the testbench top
package spol_pkg;

  // list geometry
  localparam int DEPTH       = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int POS_W       = 5;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int KEY_W       = 8;
  localparam int TAG_W       = 8;
  localparam int ENTRY_W     = KEY_W + TAG_W;
  localparam int COUNT_OUT_W = 6;

  // operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_WALK,
    ST_INS_HEAD,
    ST_RD_WAIT,
    ST_RM_SHIFT,
    ST_PUSH
  } state_t;

  // input request payload
  typedef struct packed {
    op_t                operation;
    logic [KEY_W-1:0]   prio_key;
    logic [TAG_W-1:0]   entry_tag;
    logic [POS_W-1:0]   position;
  } in_req_t;

  // result payload
  typedef struct packed {
    status_t                  status;
    logic [KEY_W-1:0]         out_key;
    logic [TAG_W-1:0]         out_tag;
    logic [COUNT_OUT_W-1:0]   entry_count;
  } out_rsp_t;

endpackage

// File: rtl/core/stable_priority_ordered_list.sv
// Stable priority-ordered list of DEPTH (key, tag) entries held in one synchronous
// ram, kept in descending key order with first-come-first-served order among equal
// keys. One request is worked at a time; in_ready is high while the block is idle.
// A read fetches its entry from the ram and then loads the result. An insert into a
// full or empty list goes straight to the final step; otherwise each entry with a
// lower key is moved down one slot, one ram read and write per cycle.
// A remove at index p moves each later entry up one slot in the same way.
// Out-of-range requests go straight to the final step. The result register frees the next request
// as soon as the result is loaded; a stalled output holds the sequencer only at
// its final step. No clearing pass is needed after reset.
// depends on spol_pkg and spol_ram
module stable_priority_ordered_list
  import spol_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  localparam int JW = CNT_W + 1;

  state_t             state_r, state_nxt;
  in_req_t            req_r, req_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  out_rsp_t           res_r, res_nxt;
  out_rsp_t           out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [KEY_W-1:0]   rd_key;
  logic [TAG_W-1:0]   rd_tag;

  logic               cnt_full;
  logic               cnt_empty;
  logic               pos_bad;
  logic               walk_shift;
  logic               more1;
  logic               more2;
  logic               out_free;
  logic [JW-1:0]      j_p1;
  logic [JW-1:0]      j_p2;
  logic [JW-1:0]      cnt_ext;
  logic [CNT_W-1:0]   j_m1;
  logic [CNT_W-1:0]   cnt_m1;
  logic [CNT_W-1:0]   cnt_p1;

  // entry storage: key in the upper byte, tag in the lower
  spol_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key = ram_rdata[ENTRY_W-1:TAG_W];
  assign rd_tag = ram_rdata[TAG_W-1:0];

  // shared conditions
  assign cnt_full   = (count_r == CNT_W'(DEPTH));
  assign cnt_empty  = (count_r == '0);
  assign pos_bad    = (CMP_W'(in_data.position) >= CMP_W'(count_r));
  assign walk_shift = (rd_key < req_r.prio_key);
  assign j_p1       = {1'b0, j_r} + JW'(1);
  assign j_p2       = {1'b0, j_r} + JW'(2);
  assign cnt_ext    = {1'b0, count_r};
  assign more1      = (j_p1 < cnt_ext);
  assign more2      = (j_p2 < cnt_ext);
  assign j_m1       = j_r - CNT_W'(1);
  assign cnt_m1     = count_r - CNT_W'(1);
  assign cnt_p1     = count_r + CNT_W'(1);
  assign out_free   = !out_valid_r || out_ready;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_data.operation)
            OP_INSERT: begin
              state_nxt = (cnt_full || cnt_empty) ? ST_PUSH : ST_INS_WALK;
            end
            OP_READ, OP_REMOVE: begin
              state_nxt = pos_bad ? ST_PUSH : ST_RD_WAIT;
            end
            default: state_nxt = ST_PUSH;
          endcase
        end
      end
      ST_INS_WALK: begin
        if (walk_shift) begin
          state_nxt = (j_r == '0) ? ST_INS_HEAD : ST_INS_WALK;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_INS_HEAD: state_nxt = ST_PUSH;
      ST_RD_WAIT: begin
        state_nxt = (req_r.operation == OP_REMOVE && more1) ? ST_RM_SHIFT : ST_PUSH;
      end
      ST_RM_SHIFT: state_nxt = more2 ? ST_RM_SHIFT : ST_PUSH;
      ST_PUSH:     state_nxt = out_free ? ST_IDLE : ST_PUSH;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ram control and datapath updates
  always_comb begin
    req_nxt       = req_r;
    j_nxt         = j_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = {req_r.prio_key, req_r.entry_tag};
    ram_raddr     = '0;

    case (state_r)
      ST_IDLE: begin
        req_nxt = in_data;
        res_nxt = '{status: STAT_OK, out_key: '0, out_tag: '0, entry_count: '0};
        case (in_data.operation)
          OP_INSERT: begin
            // walk starts at the tail
            ram_raddr = cnt_m1[IDX_W-1:0];
            j_nxt     = cnt_m1;
            if (in_valid && cnt_full) begin
              res_nxt.status = STAT_FULL;
            end else if (in_valid && cnt_empty) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = {in_data.prio_key, in_data.entry_tag};
              count_nxt = cnt_p1;
            end
          end
          OP_READ, OP_REMOVE: begin
            ram_raddr = IDX_W'(in_data.position);
            j_nxt     = CNT_W'(in_data.position);
            if (pos_bad) begin
              res_nxt.status = STAT_RANGE;
            end
          end
          default: ;
        endcase
      end
      ST_INS_WALK: begin
        // lower keys move down one slot; equal keys stay ahead of the new entry
        ram_we    = 1'b1;
        ram_waddr = j_p1[IDX_W-1:0];
        if (walk_shift) begin
          ram_wdata = ram_rdata;
          ram_raddr = j_m1[IDX_W-1:0];
          j_nxt     = j_m1;
        end else begin
          count_nxt = cnt_p1;
        end
      end
      ST_INS_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        count_nxt = cnt_p1;
      end
      ST_RD_WAIT: begin
        res_nxt.out_key = rd_key;
        res_nxt.out_tag = rd_tag;
        ram_raddr       = j_p1[IDX_W-1:0];
        if (req_r.operation == OP_REMOVE && !more1) begin
          count_nxt = cnt_m1;
        end
      end
      ST_RM_SHIFT: begin
        // close the gap one entry per cycle
        ram_we    = 1'b1;
        ram_waddr = j_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        if (more2) begin
          ram_raddr = j_p2[IDX_W-1:0];
          j_nxt     = j_p1[CNT_W-1:0];
        end else begin
          count_nxt = cnt_m1;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_nxt             = res_r;
          out_nxt.entry_count = COUNT_OUT_W'(count_r);
          out_valid_nxt       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    j_r   <= j_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  // entry count never exceeds the list depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(DEPTH) >= count_r)
    else $error("entry count above depth");

  // a new result only appears after the final sequencer step
  a_out_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == ST_PUSH))
    else $error("result loaded outside final step");

  // a full status always reports a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == STAT_FULL) |->
      (out_r.entry_count == COUNT_OUT_W'(DEPTH)))
    else $error("full status with list not full");

  // the count only changes as a request finishes its ram work
  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |-> (state_r == ST_PUSH))
    else $error("count changed mid request");

  // at most one entry gained or lost per request
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CNT_W'(1) || count_r == $past(count_r) - CNT_W'(1)))
    else $error("count moved by more than one");
`endif

endmodule

// File: rtl/core/spol_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module spol_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: test/spol_checker.sv
// response checker for the stable priority-ordered list: watches both channels,
// predicts each response and compares it; depends on spol_pkg only
`timescale 1ns / 1ps
module spol_checker
  import spol_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  out_rsp_t out_data,
  output int       fail_count,
  output int       pending
);

  // shadow copy of the list
  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [TAG_W-1:0] tag_mem [DEPTH];
  int               held;
  int               mismatches;
  out_rsp_t         pending_rsps [$];

  // apply one request to the shadow list and return the response it earns
  function automatic out_rsp_t apply_request(in_req_t req);
    out_rsp_t rsp;
    int       slot;
    rsp = '0;
    rsp.status = STAT_OK;
    case (req.operation)
      OP_INSERT: begin
        if (held >= DEPTH) begin
          rsp.status = STAT_FULL;
        end else begin
          // first lower key wins, so equal keys keep arrival order
          slot = held;
          for (int i = held - 1; i >= 0; i--)
            if (key_mem[i] < req.prio_key) slot = i;
          for (int i = held; i > slot; i--) begin
            key_mem[i] = key_mem[i-1];
            tag_mem[i] = tag_mem[i-1];
          end
          key_mem[slot] = req.prio_key;
          tag_mem[slot] = req.entry_tag;
          held++;
        end
      end
      OP_READ, OP_REMOVE: begin
        if (int'(req.position) >= held) begin
          rsp.status = STAT_RANGE;
        end else begin
          rsp.out_key = key_mem[req.position];
          rsp.out_tag = tag_mem[req.position];
          if (req.operation == OP_REMOVE) begin
            for (int i = int'(req.position); i + 1 < held; i++) begin
              key_mem[i] = key_mem[i+1];
              tag_mem[i] = tag_mem[i+1];
            end
            held--;
          end
        end
      end
      default: ;
    endcase
    rsp.entry_count = held[COUNT_OUT_W-1:0];
    return rsp;
  endfunction

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  // sample both handshakes at the clock edge
  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst_n) begin
      held = 0;
      mismatches = 0;
      pending_rsps.delete();
    end else begin
      if (in_valid && in_ready)
        pending_rsps = {pending_rsps, apply_request(in_data)};
      if (out_valid && out_ready) begin
        if (pending_rsps.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected response, expected none, actual %p", $time, out_data);
        end else begin
          want = pending_rsps.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("out_key", 32'(want.out_key), 32'(out_data.out_key));
          check_field("out_tag", 32'(want.out_tag), 32'(out_data.out_tag));
          check_field("entry_count", 32'(want.entry_count), 32'(out_data.entry_count));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= pending_rsps.size();
  end

endmodule

// File: test/tb.sv
// testbench top for stable_priority_ordered_list: drives requests with random
// gaps and output stalls, gives the verdict; depends on spol_pkg, spol_checker and the list
`timescale 1ns / 1ps
module tb;
  import spol_pkg::*;

  localparam op_t OP_UNUSED   = op_t'(2'd3);
  localparam int  N_RANDOM    = 1200;
  localparam int  LONG_HOLD_AT = 1000;

  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_rsp_t out_data;
  int       fail_count;
  int       pending;
  int       occupancy;
  bit       steady;

  stable_priority_ordered_list dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  spol_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // offer one request after an optional gap, hold it until taken
  task automatic send_request(input op_t op, input logic [KEY_W-1:0] key,
                              input logic [TAG_W-1:0] tag, input logic [POS_W-1:0] pos);
    int gap;
    int r;
    gap = 0;
    r = $urandom_range(0, 99);
    if (!steady) begin
      if (r >= 90) gap = $urandom_range(10, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op, key, tag, pos};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // keep an entry count so positions can target live entries
    if (op == OP_INSERT && occupancy < DEPTH) occupancy++;
    if (op == OP_REMOVE && int'(pos) < occupancy) occupancy--;
  endtask

  // receiver: short stalls, quiet stretches, and one long hold that backs up the block
  initial begin
    int cycles;
    int stall;
    int r;
    cycles = 0;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles == LONG_HOLD_AT) begin
        stall = 400;
      end else if (stall == 0) begin
        r = $urandom_range(0, 99);
        if (cycles % 500 < 150) stall = 0;
        else if (r >= 95) stall = $urandom_range(10, 50);
        else if (r >= 70) stall = $urandom_range(1, 3);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus and verdict
  initial begin
    mix_t mix;
    int   sent;
    int   phase_len;
    int   r;
    int   ins_pct;
    int   rd_pct;
    op_t  op;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    occupancy = 0;
    steady    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, ignored code, ordering among equal keys, range errors
    send_request(OP_READ, 8'd0, 8'd0, 5'd0);
    send_request(OP_REMOVE, 8'd0, 8'd0, 5'd0);
    send_request(OP_UNUSED, 8'hFF, 8'hFF, 5'd31);
    send_request(OP_INSERT, 8'd0, 8'h01, 5'd0);
    send_request(OP_INSERT, 8'd255, 8'hFF, 5'd31);
    send_request(OP_INSERT, 8'd128, 8'hA0, 5'd0);
    send_request(OP_INSERT, 8'd128, 8'hA1, 5'd0);
    send_request(OP_INSERT, 8'd128, 8'hA2, 5'd0);
    // equal-key group sits at the tail: new entry goes last
    send_request(OP_INSERT, 8'd0, 8'h02, 5'd0);
    send_request(OP_INSERT, 8'd255, 8'hFE, 5'd0);
    send_request(OP_INSERT, 8'd64, 8'h40, 5'd0);
    send_request(OP_READ, 8'd0, 8'd0, 5'd0);
    send_request(OP_READ, 8'd0, 8'd0, 5'd3);
    send_request(OP_READ, 8'd0, 8'd0, 5'd7);
    send_request(OP_READ, 8'd0, 8'd0, 5'd8);
    send_request(OP_READ, 8'd0, 8'd0, 5'd31);
    send_request(OP_REMOVE, 8'd0, 8'd0, 5'd2);
    send_request(OP_REMOVE, 8'd0, 8'd0, 5'd6);
    send_request(OP_REMOVE, 8'd0, 8'd0, 5'd0);
    send_request(OP_UNUSED, 8'd0, 8'd0, 5'd0);
    send_request(OP_REMOVE, 8'd0, 8'd0, 5'd31);

    // random phases that fill, drain or churn the list
    sent = 0;
    while (sent < N_RANDOM) begin
      mix = (sent == 0) ? MIX_FILL : mix_t'($urandom_range(0, 2));
      phase_len = $urandom_range(30, 90);
      steady = ($urandom_range(0, 3) == 0);
      case (mix)
        MIX_FILL:  begin ins_pct = 85; rd_pct = 10; end
        MIX_DRAIN: begin ins_pct = 15; rd_pct = 15; end
        default:   begin ins_pct = 34; rd_pct = 33; end
      endcase
      repeat (phase_len) begin
        r = $urandom_range(0, 99);
        if (r < 2) op = OP_UNUSED;
        else if (r < 2 + ins_pct) op = OP_INSERT;
        else if (r < 2 + ins_pct + rd_pct) op = OP_READ;
        else op = OP_REMOVE;
        // a few keys from a small pool so equal keys pile up
        if ($urandom_range(0, 4) < 2) key = 8'($urandom_range(0, 3) * 85);
        else key = 8'($urandom);
        if (occupancy == 0 || $urandom_range(0, 9) == 0) pos = 5'($urandom_range(0, 31));
        else pos = 5'($urandom_range(0, occupancy - 1));
        send_request(op, key, 8'($urandom), pos);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // drain, then allow the longest operation to settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: files.f
rtl/core/spol_pkg.sv
rtl/core/spol_ram.sv
rtl/core/stable_priority_ordered_list.sv
test/spol_checker.sv
test/tb.sv
